// File: hw/rtl/sjrq_pkg.sv
// Shared types and codes for the shortest-job ready queue.
// Depends on nothing; every other file imports it.
package sjrq_pkg;

  localparam int SJRQ_DEPTH = 16;

  localparam int ID_W  = 8;
  localparam int LEN_W = 16;
  localparam int ST_W  = 2;
  localparam int OCC_W = 5;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] length;
  } entry_t;

endpackage

// File: hw/rtl/sjrq_if.sv
// Request and response channel interfaces of the ready queue.
// Depends on sjrq_pkg for the field widths.
interface sjrq_req_if
  import sjrq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ID_W-1:0]  job_id;
  logic [LEN_W-1:0] job_length;

  modport source (output valid, kind, job_id, job_length, input ready);
  modport sink   (input valid, kind, job_id, job_length, output ready);
endinterface

interface sjrq_rsp_if
  import sjrq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             out_valid;
  logic [ID_W-1:0]  out_job_id;
  logic [LEN_W-1:0] out_job_length;
  logic [ST_W-1:0]  status;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, out_valid, out_job_id, out_job_length, status, occupancy,
                  input ready);
  modport sink   (input valid, out_valid, out_job_id, out_job_length, status, occupancy,
                  output ready);
endinterface

// File: hw/rtl/sjrq_store.sv
// Job storage: one write port, one registered read port.
// Depends on sjrq_pkg for the entry type.
module sjrq_store
  import sjrq_pkg::*;
#(
  parameter int DEPTH = SJRQ_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_entry,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_entry
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/sjrq_ctrl.sv
// Sequencer of the ready queue: circular order kept by a head pointer,
// insert walks from the tail with one shared length compare per step.
// Depends on sjrq_pkg and the channel interfaces.
module sjrq_ctrl
  import sjrq_pkg::*;
#(
  parameter int DEPTH = SJRQ_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  sjrq_req_if.sink      req,
  sjrq_rsp_if.source    rsp,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output entry_t        wr_entry,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  entry_t        rd_entry
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_EXT  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

  logic [2:0]      state;
  logic [AW-1:0]   head;
  logic [CW-1:0]   count;
  logic [AW-1:0]   wr_ptr;
  logic [CW-1:0]   steps;
  entry_t          key;
  logic            pend_pop;
  logic [ST_W-1:0] pend_status;
  logic            out_full;

  logic            start;
  logic            shift;
  logic            can_load;
  logic [AW:0]     tail_sum;
  logic [AW-1:0]   tail;
  logic [AW-1:0]   prev_ptr;
  logic [AW-1:0]   head_inc;

  assign req.ready = (state == S_IDLE);
  assign start     = req.valid && req.ready;
  assign shift     = (rd_entry.length >= key.length);
  assign can_load  = !out_full || rsp.ready;

  always_comb begin
    tail_sum = {1'b0, head} + (AW + 1)'(count);
    if (tail_sum >= DEPTH_EXT) begin
      tail_sum = tail_sum - DEPTH_EXT;
    end
    tail     = tail_sum[AW-1:0];
    prev_ptr = (wr_ptr == '0) ? LAST_ADDR : wr_ptr - 1'b1;
    head_inc = (head == LAST_ADDR) ? '0 : head + 1'b1;
  end

  always_comb begin
    wr_en    = (state == S_CMP) || (state == S_PUT);
    wr_addr  = wr_ptr;
    wr_entry = (state == S_CMP && shift) ? rd_entry : key;
    rd_en    = (state == S_RD) || (state == S_POP);
    rd_addr  = (state == S_POP) ? head : prev_ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      out_full <= 1'b0;
    end else begin
      // the finish step reloads the output word itself
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        out_full <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            key.id      <= req.job_id;
            key.length  <= req.job_length;
            wr_ptr      <= tail;
            steps       <= count;
            pend_pop    <= 1'b0;
            if (req.kind == KIND_INSERT) begin
              if (count == FULL_COUNT) begin
                pend_status <= ST_FULL;
                state       <= S_FIN;
              end else if (count == '0) begin
                pend_status <= ST_OK;
                state       <= S_PUT;
              end else begin
                pend_status <= ST_OK;
                state       <= S_RD;
              end
            end else begin
              if (count == '0) begin
                pend_status <= ST_EMPTY;
                state       <= S_FIN;
              end else begin
                pend_status <= ST_OK;
                state       <= S_POP;
              end
            end
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (shift) begin
            // move the tail-side entry up one place and keep walking
            wr_ptr <= prev_ptr;
            steps  <= steps - 1'b1;
            state  <= (steps == CW'(1)) ? S_PUT : S_RD;
          end else begin
            count <= count + 1'b1;
            state <= S_FIN;
          end
        end
        S_PUT: begin
          count <= count + 1'b1;
          state <= S_FIN;
        end
        S_POP: begin
          head     <= head_inc;
          count    <= count - 1'b1;
          pend_pop <= 1'b1;
          state    <= S_FIN;
        end
        S_FIN: begin
          // hold until the output word is free
          if (can_load) begin
            out_full           <= 1'b1;
            rsp.out_valid      <= pend_pop;
            rsp.out_job_id     <= pend_pop ? rd_entry.id : '0;
            rsp.out_job_length <= pend_pop ? rd_entry.length : '0;
            rsp.status         <= pend_status;
            rsp.occupancy      <= OCC_W'(count);
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid = out_full;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("occupancy beyond depth");

  a_walk_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (steps != '0))
    else $error("insert walk ran past the head");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (count == $past(count) - 1'b1))
    else $error("pop did not drop one job");

  a_drop_keeps: assert property (@(posedge clk) disable iff (rst)
    (start && req.kind == KIND_INSERT && count == FULL_COUNT) |=> $stable(count))
    else $error("dropped insert changed occupancy");
`endif

endmodule

// File: hw/rtl/shortest_job_ready_queue_unit.sv
// Top level of the shortest-job-first ready queue.
// Depends on sjrq_pkg, the channel interfaces, sjrq_ctrl and sjrq_store.
//
//   channel  dir  word fields
//   req      in   kind, job_id, job_length
//   rsp      out  out_valid, out_job_id, out_job_length, status, occupancy
//
// An insert walks from the tail over the held jobs not shorter than the new one,
// moving each one place toward the tail, then writes the new job in the gap;
// the walk does one store read and one length compare per step. A pop reads
// the head; a dropped insert or an empty pop goes straight to the finish step.
// req.ready is high only while the sequencer is idle; one result word waits in
// the output register while the next item is taken, and the finish step holds
// while that word is still unread. Reset (rst, synchronous)
// empties the queue at once; stored entries are not cleared.
module shortest_job_ready_queue_unit
  import sjrq_pkg::*;
#(
  parameter int DEPTH = SJRQ_DEPTH
) (
  input logic        clk,
  input logic        rst,
  sjrq_req_if.sink   req,
  sjrq_rsp_if.source rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_entry;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_entry;

  sjrq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  sjrq_store #(.DEPTH(DEPTH)) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

endmodule

// File: dv/tb.sv
// Self-checking bench for shortest_job_ready_queue_unit: a sorted-array job model
// predicts every response word. Depends on sjrq_pkg, sjrq_if.sv and the RTL top.
module tb;
  import sjrq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_JOBS = 450;

  typedef struct packed {
    bit               drain;
    bit [3:0]         gap;
    logic             kind;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
  } job_req_t;

  typedef struct packed {
    logic             popped;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    logic [ST_W-1:0]  status;
    logic [OCC_W-1:0] occupancy;
  } job_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             drv_valid = 1'b0;
  logic             drv_kind = KIND_INSERT;
  logic [ID_W-1:0]  drv_id = '0;
  logic [LEN_W-1:0] drv_len = '0;
  logic             drv_ready = 1'b0;
  logic             choke = 1'b0;

  sjrq_req_if req_ch ();
  sjrq_rsp_if rsp_ch ();

  assign req_ch.valid      = drv_valid;
  assign req_ch.kind       = drv_kind;
  assign req_ch.job_id     = drv_id;
  assign req_ch.job_length = drv_len;
  assign rsp_ch.ready      = drv_ready;

  shortest_job_ready_queue_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Job model: ascending lengths, head at index 0
  logic [LEN_W-1:0] sorted_len [SJRQ_DEPTH];
  logic [ID_W-1:0]  sorted_id  [SJRQ_DEPTH];
  int               held_jobs = 0;

  job_req_t job_feed [$];
  job_rsp_t result_due [$];

  int req_sent_cnt  = 0;
  int req_taken_cnt = 0;
  int rsp_taken_cnt = 0;
  int mismatch_cnt  = 0;
  int cycle_cnt     = 0;

  function automatic job_rsp_t sjf_step(logic kind, logic [ID_W-1:0] id,
                                        logic [LEN_W-1:0] len);
    job_rsp_t r;
    int pos;
    r = '0;
    r.status = ST_OK;
    if (kind == KIND_INSERT) begin
      if (held_jobs >= SJRQ_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_jobs && sorted_len[pos] < len) pos++;
        for (int i = held_jobs; i > pos; i--) begin
          sorted_len[i] = sorted_len[i-1];
          sorted_id[i]  = sorted_id[i-1];
        end
        sorted_len[pos] = len;
        sorted_id[pos]  = id;
        held_jobs++;
      end
    end else if (held_jobs == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.popped = 1'b1;
      r.id     = sorted_id[0];
      r.len    = sorted_len[0];
      for (int i = 1; i < held_jobs; i++) begin
        sorted_len[i-1] = sorted_len[i];
        sorted_id[i-1]  = sorted_id[i];
      end
      held_jobs--;
    end
    r.occupancy = OCC_W'(held_jobs);
    return r;
  endfunction

  task automatic push_job(logic kind, logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                          int gap);
    job_req_t j;
    j.drain = 1'b0;
    j.gap   = 4'(gap);
    j.kind  = kind;
    j.id    = id;
    j.len   = len;
    job_feed.push_back(j);
  endtask

  task automatic push_drain();
    job_req_t j;
    j = '0;
    j.drain = 1'b1;
    job_feed.push_back(j);
  endtask

  // Driver: one word per job entry; drain markers send none and hold until all results are back
  bit [3:0] gap_left = '0;
  job_req_t nxt_job;

  always @(negedge clk) begin
    if (!rst && (!drv_valid || req_taken_cnt == req_sent_cnt)) begin
      if (gap_left != 0) begin
        drv_valid <= 1'b0;
        gap_left  <= gap_left - 1'b1;
      end else if (job_feed.size() != 0) begin
        nxt_job = job_feed[0];
        if (nxt_job.drain) begin
          drv_valid <= 1'b0;
          if (result_due.size() == 0) void'(job_feed.pop_front());
        end else begin
          void'(job_feed.pop_front());
          drv_valid    <= 1'b1;
          drv_kind     <= nxt_job.kind;
          drv_id       <= nxt_job.id;
          drv_len      <= nxt_job.len;
          req_sent_cnt <= req_sent_cnt + 1;
          gap_left     <= nxt_job.gap;
        end
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall after each word, with calm stretches
  int  rsp_seen_cnt = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;
  int  st;

  always @(negedge clk) begin
    if (rst) begin
      drv_ready <= 1'b0;
    end else begin
      st = stall_left;
      if (rsp_taken_cnt != rsp_seen_cnt) begin
        rsp_seen_cnt = rsp_taken_cnt;
        st = calm ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 15) == 0) calm = !calm;
      end
      if (st != 0) begin
        drv_ready <= 1'b0;
        stall_left = st - 1;
      end else begin
        drv_ready <= !choke;
        stall_left = 0;
      end
    end
  end

  // Long receiver hold-off so the queue backs up into the request side
  int choke_left = 0;
  bit choke_done = 1'b0;

  always @(negedge clk) begin
    if (!choke_done && req_taken_cnt >= 150) begin
      choke_done = 1'b1;
      choke_left = 400;
    end
    choke <= (choke_left != 0);
    if (choke_left != 0) choke_left--;
  end

  // Monitor: predict on each accepted request, check each accepted response
  job_rsp_t got;
  job_rsp_t want;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** shortest_job_ready_queue_unit: FAILED **");
      $finish;
    end else if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        req_taken_cnt++;
        result_due.push_back(sjf_step(req_ch.kind, req_ch.job_id, req_ch.job_length));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_taken_cnt++;
        got.popped    = rsp_ch.out_valid;
        got.id        = rsp_ch.out_job_id;
        got.len       = rsp_ch.out_job_length;
        got.status    = rsp_ch.status;
        got.occupancy = rsp_ch.occupancy;
        if (result_due.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("response word %0d with nothing expected: pop=%0b id=%0d len=%0d st=%0d occ=%0d",
                     rsp_taken_cnt, got.popped, got.id, got.len, got.status, got.occupancy);
          mismatch_cnt++;
        end else begin
          want = result_due.pop_front();
          if (got.popped !== want.popped || got.id !== want.id || got.len !== want.len ||
              got.status !== want.status || got.occupancy !== want.occupancy) begin
            if (mismatch_cnt < 10) begin
              $display("response word %0d mismatch:", rsp_taken_cnt);
              $display("  expected pop=%0b id=%0d len=%0d st=%0d occ=%0d",
                       want.popped, want.id, want.len, want.status, want.occupancy);
              $display("  actual   pop=%0b id=%0d len=%0d st=%0d occ=%0d",
                       got.popped, got.id, got.len, got.status, got.occupancy);
            end
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Stimulus and end of run
  int made;
  int span;
  int ins_pct;
  int len_mode;
  bit quiet;
  logic [LEN_W-1:0] rlen;

  initial begin
    // pop on an empty queue
    push_job(KIND_POP, 8'hFF, 16'hFFFF, 0);
    // extremes, then equal lengths so the newest goes first
    push_job(KIND_INSERT, 8'h00, 16'hFFFF, 1);
    push_job(KIND_INSERT, 8'hFF, 16'h0000, 0);
    push_job(KIND_INSERT, 8'h01, 16'd100, 0);
    push_job(KIND_INSERT, 8'h02, 16'd100, 2);
    push_job(KIND_INSERT, 8'h03, 16'd100, 0);
    push_job(KIND_POP, 8'h00, 16'h0000, 0);
    push_job(KIND_POP, 8'hAA, 16'h5555, 3);
    // fill to the top
    for (int i = 0; i < 13; i++)
      push_job(KIND_INSERT, 8'h10 + 8'(i * 37),
               (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'((i * 5003) ^ 16'hA5A5),
               i % 3);
    // insert into a full queue is dropped
    push_job(KIND_INSERT, 8'h55, 16'h0001, 0);
    push_job(KIND_POP, 8'h00, 16'h0000, 0);
    push_job(KIND_POP, 8'h00, 16'h0000, 0);
    push_drain();

    made = 0;
    while (made < RANDOM_JOBS) begin
      span     = $urandom_range(10, 60);
      ins_pct  = ($urandom_range(0, 2) == 0) ? 50 : ($urandom_range(0, 1) ? 85 : 15);
      len_mode = $urandom_range(0, 2);
      quiet    = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < span && made < RANDOM_JOBS; k++) begin
        case (len_mode)
          0: rlen = 16'($urandom_range(0, 7));
          1: rlen = 16'($urandom);
          default: rlen = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 2));
        endcase
        push_job(($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_POP,
                 8'($urandom), rlen, quiet ? 0 : $urandom_range(0, 9));
        made++;
      end
      if ($urandom_range(0, 4) == 0) push_drain();
    end

    @(negedge clk);
    while (rst) @(negedge clk);
    while (job_feed.size() != 0 || (drv_valid && req_taken_cnt != req_sent_cnt) ||
           result_due.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_cnt == 0 && result_due.size() == 0) begin
      $display("** shortest_job_ready_queue_unit: PASSED **");
    end else begin
      $display("** shortest_job_ready_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: shortest_job_ready_queue_unit.f
hw/rtl/sjrq_pkg.sv
hw/rtl/sjrq_if.sv
hw/rtl/sjrq_store.sv
hw/rtl/sjrq_ctrl.sv
hw/rtl/shortest_job_ready_queue_unit.sv
dv/tb.sv
